[hw/rtl/log_analysis_table_engine_top_defines.svh]
// Assertion macros shared by the log analysis table engine RTL.
`ifndef LOG_ANALYSIS_TABLE_ENGINE_TOP_DEFINES_SVH
`define LOG_ANALYSIS_TABLE_ENGINE_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define LATE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its cause.
`define LATE_ASSERT_IMPLY(label, clk, rst_n, cause, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its cause.
`define LATE_ASSERT_NEXT(label, clk, rst_n, cause, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/late_pkg.sv]
// Shared constants, codes and types of the log analysis table engine.
`default_nettype none

package late_pkg;

	// Table geometry
	localparam int TXN_SLOTS  = 16;
	localparam int PAGE_SLOTS = 16;
	localparam int SCAN_N     = (TXN_SLOTS > PAGE_SLOTS) ? TXN_SLOTS : PAGE_SLOTS;
	localparam int SCAN_W     = $clog2(SCAN_N);
	localparam int TXN_AW     = $clog2(TXN_SLOTS);
	localparam int PAGE_AW    = $clog2(PAGE_SLOTS);
	localparam int TXN_CW     = $clog2(TXN_SLOTS + 1);
	localparam int PAGE_CW    = $clog2(PAGE_SLOTS + 1);

	// Field widths
	localparam int MODE_W    = 3;
	localparam int KIND_W    = 3;
	localparam int LSN_W     = 32;
	localparam int ID_W      = 32;
	localparam int SLOT_W    = 4;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 5;
	localparam int COUNT_MAX = 2**COUNT_W - 1;
	localparam int ENTRY_W   = ID_W + LSN_W;

	// Item modes
	localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SEED_TXN  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SEED_PAGE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_LOG       = 3'd3;
	localparam logic [MODE_W-1:0] MODE_READ_TXN  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_READ_PAGE = 3'd5;

	// Log record kinds
	localparam logic [KIND_W-1:0] KIND_BEGIN   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_COMMIT  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_TXN_END = 3'd2;
	localparam logic [KIND_W-1:0] KIND_UPDATE  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLR     = 3'd4;
	localparam logic [KIND_W-1:0] KIND_ABORT   = 3'd5;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TXN_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_PAGE_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_SLOT_EMPTY = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [KIND_W-1:0] record_kind;
		logic [LSN_W-1:0]  log_number;
		logic [ID_W-1:0]   txn_ident;
		logic [ID_W-1:0]   page_ident;
		logic [SLOT_W-1:0] slot_index;
	} late_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  txn_count;
		logic [COUNT_W-1:0]  page_count;
		logic                redo_start_valid;
		logic [LSN_W-1:0]    redo_start;
		logic                page_added;
		logic [ID_W-1:0]     read_key;
		logic [LSN_W-1:0]    read_log_number;
	} late_result_t;

	// Clamp an entry count to the width of the count fields.
	function automatic logic [COUNT_W-1:0] sat_count(input logic [31:0] n);
		if (n > 32'(COUNT_MAX)) begin
			return COUNT_W'(COUNT_MAX);
		end
		return n[COUNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

[hw/rtl/late_ram.sv]
// Simple dual-port synchronous RAM with one write port and a registered read port.
`default_nettype none

module late_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[hw/rtl/late_engine.sv]
// Table sequencer: scans both table memories, then commits each item's table updates.
`default_nettype none
`include "log_analysis_table_engine_top_defines.svh"

module late_engine (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire late_pkg::late_item_t  item,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output late_pkg::late_result_t     res
);
	import late_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_COMMIT} state_t;

	state_t               state_q;
	late_item_t           item_q;
	logic [SCAN_W-1:0]    idx_q;
	logic [SCAN_W-1:0]    idx_s1;
	logic                 scan_s1;
	logic                 tin_s1;
	logic                 tv_s1;
	logic                 pin_s1;
	logic                 pv_s1;
	logic [TXN_SLOTS-1:0] txn_valid_q;
	logic [PAGE_SLOTS-1:0] page_valid_q;
	logic [TXN_CW-1:0]    txn_count_q;
	logic [PAGE_CW-1:0]   page_count_q;
	logic                 t_hit_q;
	logic                 t_free_q;
	logic                 p_hit_q;
	logic                 p_free_q;
	logic [TXN_AW-1:0]    t_hit_slot_q;
	logic [TXN_AW-1:0]    t_free_slot_q;
	logic [PAGE_AW-1:0]   p_hit_slot_q;
	logic [PAGE_AW-1:0]   p_free_slot_q;
	logic                 have_all_q;
	logic                 have_excl_q;
	logic [LSN_W-1:0]     min_all_q;
	logic [LSN_W-1:0]     min_excl_q;
	logic                 rd_hit_q;
	logic [ID_W-1:0]      rd_key_q;
	logic [LSN_W-1:0]     rd_log_q;

	// Memory ports
	logic [TXN_AW-1:0]    t_raddr;
	logic [PAGE_AW-1:0]   p_raddr;
	logic [ENTRY_W-1:0]   t_rdata;
	logic [ENTRY_W-1:0]   p_rdata;
	logic                 t_we;
	logic                 p_we;
	logic [TXN_AW-1:0]    t_waddr;
	logic [PAGE_AW-1:0]   p_waddr;
	logic [ENTRY_W-1:0]   t_wdata;
	logic [ENTRY_W-1:0]   p_wdata;

	// Scan and compare signals
	logic                 t_in;
	logic                 p_in;
	logic                 scan_last;
	logic [ID_W-1:0]      t_key;
	logic [LSN_W-1:0]     t_log;
	logic [ID_W-1:0]      p_key;
	logic [LSN_W-1:0]     p_log;
	logic                 t_match;
	logic                 p_match;
	logic                 p_less_all;
	logic                 p_less_excl;
	logic                 slot_match;

	// Item decode and commit outcome
	logic                 do_clear;
	logic                 do_tput;
	logic                 do_pput;
	logic                 p_over;
	logic                 do_drop;
	logic                 do_rtxn;
	logic                 do_rpage;
	logic                 commit_fire;
	logic                 t_ok;
	logic                 p_ok;
	logic                 t_ins;
	logic                 t_del;
	logic                 p_ins;
	logic [TXN_CW-1:0]    txn_count_nx;
	logic [PAGE_CW-1:0]   page_count_nx;
	logic [STATUS_W-1:0]  status_nx;
	logic                 have_nx;
	logic [LSN_W-1:0]     min_nx;

	late_ram #(.DEPTH(TXN_SLOTS), .WIDTH(ENTRY_W)) u_txn_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	late_ram #(.DEPTH(PAGE_SLOTS), .WIDTH(ENTRY_W)) u_page_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	// Scan issue side: one slot of each table per cycle
	assign t_raddr   = idx_q[TXN_AW-1:0];
	assign p_raddr   = idx_q[PAGE_AW-1:0];
	assign t_in      = 32'(idx_q) < TXN_SLOTS;
	assign p_in      = 32'(idx_q) < PAGE_SLOTS;
	assign scan_last = 32'(idx_q) == 32'(SCAN_N - 1);

	// Compare side: memory data of the slot issued in the previous cycle
	assign t_key       = t_rdata[ENTRY_W-1:LSN_W];
	assign t_log       = t_rdata[LSN_W-1:0];
	assign p_key       = p_rdata[ENTRY_W-1:LSN_W];
	assign p_log       = p_rdata[LSN_W-1:0];
	assign t_match     = tv_s1 && (t_key == item_q.txn_ident);
	assign p_match     = pv_s1 && (p_key == item_q.page_ident);
	assign p_less_all  = !have_all_q || (p_log < min_all_q);
	assign p_less_excl = !have_excl_q || (p_log < min_excl_q);
	assign slot_match  = 32'(idx_s1) == 32'(item_q.slot_index);

	always_comb begin
		do_clear = 1'b0;
		do_tput  = 1'b0;
		do_pput  = 1'b0;
		p_over   = 1'b0;
		do_drop  = 1'b0;
		do_rtxn  = 1'b0;
		do_rpage = 1'b0;
		unique case (item_q.mode)
			MODE_CLEAR:     do_clear = 1'b1;
			MODE_SEED_TXN:  do_tput = 1'b1;
			MODE_SEED_PAGE: begin
				do_pput = 1'b1;
				p_over  = 1'b1;
			end
			MODE_LOG: begin
				unique case (item_q.record_kind) inside
					KIND_BEGIN, KIND_ABORT:    do_tput = 1'b1;
					KIND_COMMIT, KIND_TXN_END: do_drop = 1'b1;
					KIND_UPDATE, KIND_CLR: begin
						do_tput = 1'b1;
						do_pput = 1'b1;
					end
					default: ;
				endcase
			end
			MODE_READ_TXN:  do_rtxn = 1'b1;
			MODE_READ_PAGE: do_rpage = 1'b1;
			default: ;
		endcase
	end

	// Commit: an existing entry wins over the lowest free slot
	assign commit_fire = (state_q == ST_COMMIT) && res_ready;
	assign t_ok  = t_hit_q || t_free_q;
	assign p_ok  = p_hit_q || p_free_q;
	assign t_ins = do_tput && !t_hit_q && t_free_q;
	assign t_del = do_drop && t_hit_q;
	assign p_ins = do_pput && !p_hit_q && p_free_q;

	assign t_we    = commit_fire && do_tput && t_ok;
	assign t_waddr = t_hit_q ? t_hit_slot_q : t_free_slot_q;
	assign t_wdata = {item_q.txn_ident, item_q.log_number};
	assign p_we    = commit_fire && do_pput && (p_hit_q ? p_over : p_free_q);
	assign p_waddr = p_hit_q ? p_hit_slot_q : p_free_slot_q;
	assign p_wdata = {item_q.page_ident, item_q.log_number};

	assign txn_count_nx  = do_clear ? '0 :
		txn_count_q + TXN_CW'(t_ins) - TXN_CW'(t_del);
	assign page_count_nx = do_clear ? '0 : page_count_q + PAGE_CW'(p_ins);

	always_comb begin
		status_nx = ST_OK;
		if (do_tput && !t_ok) begin
			status_nx = ST_TXN_FULL;
		end else if (do_pput && !p_ok) begin
			status_nx = ST_PAGE_FULL;
		end else if ((do_rtxn || do_rpage) && !rd_hit_q) begin
			status_nx = ST_SLOT_EMPTY;
		end
	end

	// Redo start: fold a stored log number into the scan minimum of the other pages
	always_comb begin
		have_nx = have_all_q;
		min_nx  = min_all_q;
		if (do_clear) begin
			have_nx = 1'b0;
			min_nx  = '0;
		end else if (do_pput && p_over && p_ok) begin
			have_nx = 1'b1;
			min_nx  = (have_excl_q && (min_excl_q < item_q.log_number)) ?
				min_excl_q : item_q.log_number;
		end else if (p_ins) begin
			have_nx = 1'b1;
			min_nx  = (have_all_q && (min_all_q < item_q.log_number)) ?
				min_all_q : item_q.log_number;
		end
	end

	assign item_ready = (state_q == ST_IDLE);
	assign res_valid  = (state_q == ST_COMMIT);

	always_comb begin
		res.status           = status_nx;
		res.txn_count        = sat_count(32'(txn_count_nx));
		res.page_count       = sat_count(32'(page_count_nx));
		res.redo_start_valid = have_nx;
		res.redo_start       = min_nx;
		res.page_added       = p_ins && !p_over;
		res.read_key         = rd_key_q;
		res.read_log_number  = rd_log_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			item_q        <= '0;
			idx_q         <= '0;
			idx_s1        <= '0;
			scan_s1       <= 1'b0;
			tin_s1        <= 1'b0;
			tv_s1         <= 1'b0;
			pin_s1        <= 1'b0;
			pv_s1         <= 1'b0;
			txn_valid_q   <= '0;
			page_valid_q  <= '0;
			txn_count_q   <= '0;
			page_count_q  <= '0;
			t_hit_q       <= 1'b0;
			t_free_q      <= 1'b0;
			p_hit_q       <= 1'b0;
			p_free_q      <= 1'b0;
			t_hit_slot_q  <= '0;
			t_free_slot_q <= '0;
			p_hit_slot_q  <= '0;
			p_free_slot_q <= '0;
			have_all_q    <= 1'b0;
			have_excl_q   <= 1'b0;
			min_all_q     <= '0;
			min_excl_q    <= '0;
			rd_hit_q      <= 1'b0;
			rd_key_q      <= '0;
			rd_log_q      <= '0;
		end else begin
			scan_s1 <= (state_q == ST_SCAN);

			// Compare stage: record hits, first free slots, minimums and the read slot
			if (scan_s1) begin
				if (t_match && !t_hit_q) begin
					t_hit_q      <= 1'b1;
					t_hit_slot_q <= idx_s1[TXN_AW-1:0];
				end
				if (tin_s1 && !tv_s1 && !t_free_q) begin
					t_free_q      <= 1'b1;
					t_free_slot_q <= idx_s1[TXN_AW-1:0];
				end
				if (p_match && !p_hit_q) begin
					p_hit_q      <= 1'b1;
					p_hit_slot_q <= idx_s1[PAGE_AW-1:0];
				end
				if (pin_s1 && !pv_s1 && !p_free_q) begin
					p_free_q      <= 1'b1;
					p_free_slot_q <= idx_s1[PAGE_AW-1:0];
				end
				if (pv_s1 && p_less_all) begin
					have_all_q <= 1'b1;
					min_all_q  <= p_log;
				end
				if (pv_s1 && !p_match && p_less_excl) begin
					have_excl_q <= 1'b1;
					min_excl_q  <= p_log;
				end
				if (slot_match && do_rtxn && tv_s1) begin
					rd_hit_q <= 1'b1;
					rd_key_q <= t_key;
					rd_log_q <= t_log;
				end
				if (slot_match && do_rpage && pv_s1) begin
					rd_hit_q <= 1'b1;
					rd_key_q <= p_key;
					rd_log_q <= p_log;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						item_q      <= item;
						idx_q       <= '0;
						t_hit_q     <= 1'b0;
						t_free_q    <= 1'b0;
						p_hit_q     <= 1'b0;
						p_free_q    <= 1'b0;
						have_all_q  <= 1'b0;
						have_excl_q <= 1'b0;
						min_all_q   <= '0;
						min_excl_q  <= '0;
						rd_hit_q    <= 1'b0;
						rd_key_q    <= '0;
						rd_log_q    <= '0;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_s1  <= idx_q;
					tin_s1  <= t_in;
					tv_s1   <= t_in && txn_valid_q[t_raddr];
					pin_s1  <= p_in;
					pv_s1   <= p_in && page_valid_q[p_raddr];
					idx_q   <= idx_q + 1'b1;
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (res_ready) begin
						if (do_clear) begin
							txn_valid_q  <= '0;
							page_valid_q <= '0;
						end else begin
							if (t_ins) begin
								txn_valid_q[t_free_slot_q] <= 1'b1;
							end
							if (t_del) begin
								txn_valid_q[t_hit_slot_q] <= 1'b0;
							end
							if (p_ins) begin
								page_valid_q[p_free_slot_q] <= 1'b1;
							end
						end
						txn_count_q  <= txn_count_nx;
						page_count_q <= page_count_nx;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`LATE_ASSERT_ALWAYS(a_txn_count, clk, arst_n, 32'(txn_count_q) == $countones(txn_valid_q), "transaction count out of step with valid bits")
	`LATE_ASSERT_ALWAYS(a_page_count, clk, arst_n, 32'(page_count_q) == $countones(page_valid_q), "page count out of step with valid bits")
	`LATE_ASSERT_NEXT(a_txn_write_valid, clk, arst_n, t_we, txn_valid_q[$past(t_waddr)], "written transaction slot not valid")
	`LATE_ASSERT_NEXT(a_page_write_valid, clk, arst_n, p_we, page_valid_q[$past(p_waddr)], "written page slot not valid")
	`LATE_ASSERT_IMPLY(a_redo_consistent, clk, arst_n, res_valid, res.redo_start_valid == (res.page_count != '0), "redo start flag disagrees with page count")

endmodule

`default_nettype wire

[hw/rtl/log_analysis_table_engine_top.sv]
// Top level of the log analysis table engine: item and result channels.
`default_nettype none

// Rebuilds the active-transaction table and the dirty-page table of a recovery
// analysis pass, one item at a time. For each item the sequencer takes the
// item, streams both table memories slot by slot through their single read
// ports looking for the id, the first free slot, the smallest first-dirty
// log number and the slot to read, drains the memory read latency, and then
// writes back and publishes the result. A result waiting in the output
// register does not hold back the next item; only a second finished result
// stalls, in the commit step, until the output register frees up. Valid bits
// sit in flip-flops and reset clears them at once, so no clearing pass is
// needed after reset. New entries take the lowest free slot; a full table
// reports a status instead of storing.

module log_analysis_table_engine_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Item channel
	input  wire logic                           item_valid,
	output logic                                item_ready,
	input  wire logic [late_pkg::MODE_W-1:0]    mode,
	input  wire logic [late_pkg::KIND_W-1:0]    record_kind,
	input  wire logic [late_pkg::LSN_W-1:0]     log_number,
	input  wire logic [late_pkg::ID_W-1:0]      txn_ident,
	input  wire logic [late_pkg::ID_W-1:0]      page_ident,
	input  wire logic [late_pkg::SLOT_W-1:0]    slot_index,
	// Result channel
	output logic                                result_valid,
	input  wire logic                           result_ready,
	output logic      [late_pkg::STATUS_W-1:0]  status,
	output logic      [late_pkg::COUNT_W-1:0]   txn_count,
	output logic      [late_pkg::COUNT_W-1:0]   page_count,
	output logic                                redo_start_valid,
	output logic      [late_pkg::LSN_W-1:0]     redo_start,
	output logic                                page_added,
	output logic      [late_pkg::ID_W-1:0]      read_key,
	output logic      [late_pkg::LSN_W-1:0]     read_log_number
);
	import late_pkg::*;

	late_item_t   item;
	late_result_t res;
	late_result_t res_q;
	logic         res_valid;
	logic         res_ready;
	logic         result_valid_q;

	// Pack the item fields for the sequencer
	always_comb begin
		item.mode        = mode;
		item.record_kind = record_kind;
		item.log_number  = log_number;
		item.txn_ident   = txn_ident;
		item.page_ident  = page_ident;
		item.slot_index  = slot_index;
	end

	late_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// The output register frees up when empty or when its transaction completes
	assign res_ready = !result_valid_q || result_ready;

	// Hold the finished result until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_ready) begin
			result_valid_q <= res_valid;
		end
	end

	// Load the result payload together with its valid flag
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign result_valid     = result_valid_q;
	assign status           = res_q.status;
	assign txn_count        = res_q.txn_count;
	assign page_count       = res_q.page_count;
	assign redo_start_valid = res_q.redo_start_valid;
	assign redo_start       = res_q.redo_start;
	assign page_added       = res_q.page_added;
	assign read_key         = res_q.read_key;
	assign read_log_number  = res_q.read_log_number;

endmodule

`default_nettype wire
